// ===== hdl/lcc_pkg.sv =====
package lcc_pkg;

	// Graph size and fixed-point format
	localparam int MAX_NODES = 64;
	localparam int FRAC_BITS = 16;

	// Field widths
	localparam int NODE_W   = 6;
	localparam int NODE_CNT = 1 << NODE_W;
	localparam int ROW_IN_W = 64;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int FCNT_W   = 7;
	localparam int LINK_W   = 11;
	localparam int COEF_W   = 17;

	// Storage and arithmetic widths
	localparam int ROW_W     = MAX_NODES;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int NUM_W     = LINK_W + 1 + FRAC_BITS;
	localparam int DEN_W     = $clog2(MAX_NODES * (MAX_NODES - 1) + 1);
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// Stream word widths
	localparam int IN_FIELDS_W  = 2 * NODE_W + ROW_IN_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = FCNT_W + LINK_W + COEF_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [STAT_W-1:0] ST_FEW     = 2'd2;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [ROW_IN_W-1:0] row_bits;
	} lcc_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [FCNT_W-1:0] friend_count;
		logic [LINK_W-1:0] link_count;
		logic [COEF_W-1:0] coefficient;
	} lcc_res_t;

	// Count set bits of one adjacency row
	function automatic logic [FCNT_W-1:0] popcount(input logic [ROW_W-1:0] v);
		logic [FCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < ROW_W; i++) begin
			n = n + FCNT_W'(v[i]);
		end
		return n;
	endfunction

	function automatic logic node_in_range(input logic [NODE_W-1:0] x);
		return {1'b0, x} < (NODE_W + 1)'(MAX_NODES);
	endfunction

endpackage

// ===== hdl/lcc_ram.sv =====
module lcc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/lcc_div.sv =====
module lcc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lcc_pkg::NUM_W-1:0]  num,
	input  logic [lcc_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [lcc_pkg::COEF_W-1:0] quo
);

	logic                            busy_q;
	logic                            done_q;
	logic [lcc_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [lcc_pkg::DEN_W-1:0]       rem_q;
	logic [lcc_pkg::DEN_W-1:0]       den_q;
	logic [lcc_pkg::NUM_W-1:0]       acc_q;
	logic [lcc_pkg::DEN_W:0]         sh;
	logic [lcc_pkg::DEN_W:0]         diff;
	logic                            ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign sh   = {rem_q, acc_q[lcc_pkg::NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			acc_q  <= '0;
		end else begin
			// Flag the cycle after the last step
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lcc_pkg::DIV_CNT_W'(lcc_pkg::NUM_W - 1);
				rem_q  <= '0;
				den_q  <= den;
				acc_q  <= num;
			end else if (busy_q) begin
				rem_q <= ge ? diff[lcc_pkg::DEN_W-1:0] : sh[lcc_pkg::DEN_W-1:0];
				acc_q <= {acc_q[lcc_pkg::NUM_W-2:0], ge};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = acc_q[lcc_pkg::COEF_W-1:0];

endmodule

// ===== hdl/lcc_engine.sv =====
module lcc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lcc_pkg::lcc_req_t req,
	output logic              res_valid,
	input  logic              res_ready,
	output lcc_pkg::lcc_res_t res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RM_A,
		S_RM_WA,
		S_RM_B,
		S_RM_WB,
		S_Q_ROW,
		S_Q_CNT,
		S_Q_SCAN,
		S_Q_WAIT,
		S_Q_DEN,
		S_Q_DIV,
		S_DONE
	} state_t;

	state_t                           state_q;
	logic [lcc_pkg::MODE_W-1:0]       mode_q;
	logic [lcc_pkg::NODE_W-1:0]       a_q;
	logic [lcc_pkg::NODE_W-1:0]       b_q;
	logic [lcc_pkg::NODE_CNT-1:0]     present_q;
	logic [lcc_pkg::ROW_W-1:0]        friends_q;
	logic [lcc_pkg::FCNT_W-1:0]       k_q;
	logic [lcc_pkg::LINK_W-1:0]       e_q;
	logic [lcc_pkg::ADDR_W-1:0]       scan_q;
	lcc_pkg::lcc_res_t                res_q;

	// Scan pipeline: s1 = row read in flight, s2 = masked popcount
	logic                             run_s1;
	logic                             fr_s1;
	logic [lcc_pkg::ADDR_W-1:0]       idx_s1;
	logic                             pres_s1;
	logic                             run_s2;
	logic                             fr_s2;
	logic [lcc_pkg::FCNT_W-1:0]       pc_s2;

	logic                             ram_we;
	logic [lcc_pkg::ADDR_W-1:0]       ram_waddr;
	logic [lcc_pkg::ROW_W-1:0]        ram_wdata;
	logic [lcc_pkg::ADDR_W-1:0]       ram_raddr;
	logic [lcc_pkg::ROW_W-1:0]        ram_rdata;
	logic [lcc_pkg::NODE_W-1:0]       rd_node;
	logic                             pres_rd;
	logic [lcc_pkg::ROW_W-1:0]        row_rd;
	logic [lcc_pkg::ROW_W-1:0]        above;
	logic                             pa;
	logic                             pb;
	logic [lcc_pkg::FCNT_W-1:0]       k_new;
	logic [2*lcc_pkg::FCNT_W-1:0]     den_full;
	logic                             div_start;
	logic                             div_done;
	logic [lcc_pkg::COEF_W-1:0]       div_quo;
	lcc_pkg::lcc_res_t                res_idle;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Presence doubles as the row valid bit: an absent node reads as an empty row
	assign pa      = lcc_pkg::node_in_range(a_q) && present_q[a_q];
	assign pb      = lcc_pkg::node_in_range(b_q) && present_q[b_q];
	assign pres_rd = lcc_pkg::node_in_range(rd_node) && present_q[rd_node];
	assign row_rd  = pres_s1 ? ram_rdata : '0;
	assign above   = ({lcc_pkg::ROW_W{1'b1}} << idx_s1) << 1;
	assign k_new   = lcc_pkg::popcount(row_rd);
	assign den_full = k_q * (k_q - lcc_pkg::FCNT_W'(1));
	assign div_start = (state_q == S_Q_DEN);

	// Initial result of a new word: unknown node for a bad write or query
	always_comb begin
		res_idle = '0;
		if ((req.mode == lcc_pkg::MODE_WRITE && !lcc_pkg::node_in_range(req.node_a)) ||
		    (req.mode == lcc_pkg::MODE_QUERY &&
		     !(lcc_pkg::node_in_range(req.node_a) && present_q[req.node_a]))) begin
			res_idle.status = lcc_pkg::ST_UNKNOWN;
		end
	end

	// Select the row to read
	always_comb begin
		unique case (state_q)
			S_RM_B:   rd_node = b_q;
			S_Q_SCAN: rd_node = lcc_pkg::NODE_W'(scan_q);
			default:  rd_node = a_q;
		endcase
	end
	assign ram_raddr = rd_node[lcc_pkg::ADDR_W-1:0];

	// Row writes: full row on a write, one cleared bit per side on a removal
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = a_q[lcc_pkg::ADDR_W-1:0];
		ram_wdata = row_rd & ~(lcc_pkg::ROW_W'(1) << b_q);
		unique case (state_q)
			S_IDLE: begin
				ram_we    = in_valid && (req.mode == lcc_pkg::MODE_WRITE) &&
				            lcc_pkg::node_in_range(req.node_a);
				ram_waddr = req.node_a[lcc_pkg::ADDR_W-1:0];
				ram_wdata = req.row_bits[lcc_pkg::ROW_W-1:0];
			end
			S_RM_WA: begin
				ram_we = pa;
			end
			S_RM_WB: begin
				ram_we    = pb;
				ram_waddr = b_q[lcc_pkg::ADDR_W-1:0];
				ram_wdata = row_rd & ~(lcc_pkg::ROW_W'(1) << a_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	lcc_ram #(
		.WIDTH(lcc_pkg::ROW_W),
		.DEPTH(lcc_pkg::MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lcc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({e_q, 1'b0, {lcc_pkg::FRAC_BITS{1'b0}}}),
		.den   (den_full[lcc_pkg::DEN_W-1:0]),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Sequencer, scan pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= '0;
			a_q       <= '0;
			b_q       <= '0;
			present_q <= '0;
			friends_q <= '0;
			k_q       <= '0;
			e_q       <= '0;
			scan_q    <= '0;
			res_q     <= '0;
			run_s1    <= 1'b0;
			fr_s1     <= 1'b0;
			idx_s1    <= '0;
			pres_s1   <= 1'b0;
			run_s2    <= 1'b0;
			fr_s2     <= 1'b0;
			pc_s2     <= '0;
		end else begin
			// Advance the scan pipeline
			run_s1  <= (state_q == S_Q_SCAN);
			fr_s1   <= friends_q[scan_q];
			idx_s1  <= scan_q;
			pres_s1 <= pres_rd;
			run_s2  <= run_s1;
			fr_s2   <= fr_s1;
			pc_s2   <= lcc_pkg::popcount(row_rd & friends_q & above);
			if (run_s2 && fr_s2) begin
				e_q <= e_q + lcc_pkg::LINK_W'(pc_s2);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= req.mode;
						a_q    <= req.node_a;
						b_q    <= req.node_b;
						res_q  <= res_idle;
						unique case (req.mode)
							lcc_pkg::MODE_WRITE: begin
								if (lcc_pkg::node_in_range(req.node_a)) begin
									present_q[req.node_a] <= 1'b1;
								end
								state_q <= S_DONE;
							end
							lcc_pkg::MODE_REMOVE: begin
								state_q <= S_RM_A;
							end
							lcc_pkg::MODE_QUERY: begin
								if (lcc_pkg::node_in_range(req.node_a) &&
								    present_q[req.node_a]) begin
									state_q <= S_Q_ROW;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RM_A:  state_q <= S_RM_WA;
				S_RM_WA: state_q <= S_RM_B;
				S_RM_B:  state_q <= S_RM_WB;
				S_RM_WB: begin
					res_q.status <= (pa && pb) ? lcc_pkg::ST_OK : lcc_pkg::ST_UNKNOWN;
					state_q      <= S_DONE;
				end
				S_Q_ROW: state_q <= S_Q_CNT;
				S_Q_CNT: begin
					friends_q <= row_rd;
					k_q       <= k_new;
					if (k_new < lcc_pkg::FCNT_W'(2)) begin
						res_q.status       <= lcc_pkg::ST_FEW;
						res_q.friend_count <= k_new;
						state_q            <= S_DONE;
					end else begin
						scan_q  <= '0;
						e_q     <= '0;
						state_q <= S_Q_SCAN;
					end
				end
				S_Q_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == lcc_pkg::ADDR_W'(lcc_pkg::MAX_NODES - 1)) begin
						state_q <= S_Q_WAIT;
					end
				end
				S_Q_WAIT: begin
					// Drain the last rows into the link count
					if (!run_s1 && !run_s2) begin
						state_q <= S_Q_DEN;
					end
				end
				S_Q_DEN: state_q <= S_Q_DIV;
				S_Q_DIV: begin
					if (div_done) begin
						res_q.status       <= lcc_pkg::ST_OK;
						res_q.friend_count <= k_q;
						res_q.link_count   <= e_q;
						res_q.coefficient  <= div_quo;
						state_q            <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_Q_DIV)
		else $error("divider finished outside a query");

	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !run_s1 && !run_s2)
		else $error("scan pipeline busy while idle");

	a_coef_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_q.coefficient <= lcc_pkg::COEF_ONE)
		else $error("coefficient above one");

	a_link_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.status == lcc_pkg::ST_OK && mode_q == lcc_pkg::MODE_QUERY
		|-> {res_q.link_count, 1'b0} <= den_full)
		else $error("link count above possible pairs");

	a_few_friends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.status == lcc_pkg::ST_FEW
		|-> res_q.friend_count < lcc_pkg::FCNT_W'(2))
		else $error("few-friends status with two or more friends");

endmodule

// ===== hdl/local_clustering_coefficient_unit.sv =====
// Local clustering coefficient over a graph of up to 64 nodes.
// Input words arrive on s_*: s_tuser carries the mode (write row, remove
// friendship, query), s_tdata the node ids and the friend row. Every input
// word yields exactly one result word on m_*: m_tuser carries the status,
// m_tdata the friend count, link count and the coefficient 2E/(k(k-1)) with
// 16 fractional bits.
// Rows live in one 64x64 synchronous RAM; presence bits sit in flip-flops.
// A removal does a read-modify-write of both rows. A full query scans the
// 64 row slots through the RAM read port, one row slot per cycle, then runs
// a 28-step restoring divider; a query of an absent node or one with fewer
// than two friends skips both. One word is processed at a time.
// Reset clears all presence bits, so every row reads as empty; the RAM
// itself needs no clearing pass.
// A finished result moves into the output register, after which a new
// input word is taken; if m_tready stays low and the register is full, the
// engine holds its result and s_tready stays low.
module local_clustering_coefficient_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// node_a [5:0], node_b [11:6], row_bits [75:12], zero fill [79:76]
	input  logic [lcc_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode [1:0]
	input  logic [lcc_pkg::MODE_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// friend_count [6:0], link_count [17:7], coefficient [34:18], zero fill [39:35]
	output logic [lcc_pkg::OUT_DATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [lcc_pkg::STAT_W-1:0]     m_tuser
);

	lcc_pkg::lcc_req_t req;
	lcc_pkg::lcc_res_t eng_res;
	lcc_pkg::lcc_res_t out_q;
	logic              eng_valid;
	logic              eng_ready;
	logic              out_valid_q;

	// Unpack the input word
	assign req.mode     = s_tuser;
	assign req.node_a   = s_tdata[lcc_pkg::NODE_W-1:0];
	assign req.node_b   = s_tdata[2*lcc_pkg::NODE_W-1:lcc_pkg::NODE_W];
	assign req.row_bits = s_tdata[lcc_pkg::IN_FIELDS_W-1:2*lcc_pkg::NODE_W];

	lcc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.req      (req),
		.res_valid(eng_valid),
		.res_ready(eng_ready),
		.res      (eng_res)
	);

	// Output register: load when empty or being drained
	assign eng_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (eng_ready) begin
			out_valid_q <= eng_valid;
			if (eng_valid) begin
				out_q <= eng_res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{(lcc_pkg::OUT_DATA_W - lcc_pkg::OUT_FIELDS_W){1'b0}},
	                   out_q.coefficient, out_q.link_count, out_q.friend_count};

endmodule
